/* design/aging_affinity_task_picker_top_macros.svh */
// Assertion macros for the checker module.
`ifndef AGING_AFFINITY_TASK_PICKER_TOP_MACROS_SVH
`define AGING_AFFINITY_TASK_PICKER_TOP_MACROS_SVH
// same-cycle implication, reset masks the check
`define AATP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define AATP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* design/aatp_pkg.sv */
// Types and constants of the task picker.
package aatp_pkg;
  localparam int NumTasks = 16;
  localparam int SlotW    = 4;
  localparam int NumCores = 2;
  localparam int CmdW     = 2;
  localparam int PrioW    = 8;
  localparam int AffW     = 2;
  localparam int TickW    = 32;
  localparam int ScoreW   = 33;
  localparam int CntW     = 5;

  localparam logic [CmdW-1:0] CmdReady  = 2'd0;
  localparam logic [CmdW-1:0] CmdRemove = 2'd1;
  localparam logic [CmdW-1:0] CmdSelect = 2'd2;

  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [AffW-1:0]  aff;
    logic [TickW-1:0] stamp;
  } slot_rec_t;

  localparam int RecW = $bits(slot_rec_t);
endpackage

/* design/aatp_ram.sv */
// Generic single-port-write, registered-read RAM.
module aatp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* design/aging_affinity_task_picker_top.sv */
// Aging priority task picker with per-core affinity, top level.
//  channel | direction | handshake               | payload
//  in      | in        | in_valid_i/in_ready_o   | cmd, task_slot, task_priority, affinity,
//          |           |                         | core, now_tick
//  out     | out       | out_valid_o/out_ready_i | found, chosen_slot, chosen_score
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_data_i (tick_divisor)
// Make-ready and remove complete in the accept cycle; in_ready_o stays high.
// Select walks all 16 slots through the record RAM: a read state and a load state per slot,
// plus, for an eligible slot, the age divider (one quotient bit a cycle) and a compare
// state. A result not yet taken holds the scan.
// Reset empties the ready set and sets the divisor to 1; no RAM clearing.
module aging_affinity_task_picker_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [aatp_pkg::CmdW-1:0]    cmd_i,
  input  logic [aatp_pkg::SlotW-1:0]   task_slot_i,
  input  logic [aatp_pkg::PrioW-1:0]   task_priority_i,
  input  logic [aatp_pkg::AffW-1:0]    affinity_i,
  input  logic                         core_i,
  input  logic [aatp_pkg::TickW-1:0]   now_tick_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         found_o,
  output logic [aatp_pkg::SlotW-1:0]   chosen_slot_o,
  output logic signed [aatp_pkg::ScoreW-1:0] chosen_score_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [aatp_pkg::TickW-1:0]   cfg_data_i
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StLoad = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StCmp  = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  localparam int N  = aatp_pkg::NumTasks;
  localparam int SW = aatp_pkg::SlotW;
  localparam int TW = aatp_pkg::TickW;
  localparam int QW = 5;

  logic [2:0] state_q, state_d;
  logic [TW-1:0] div_q;
  logic [N-1:0] ready_q, ready_d;
  logic [SW-1:0] rank_q [N];
  logic [SW-1:0] rank_d [N];
  logic [aatp_pkg::CntW-1:0] count_q, count_d;

  logic [SW-1:0] idx_q, idx_d;
  logic          core_q, core_d;
  logic [TW-1:0] now_q, now_d;
  logic [aatp_pkg::PrioW-1:0] prio_q, prio_d;
  logic [TW-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [QW-1:0] bit_q, bit_d;
  logic          have_q, have_d;
  logic [SW-1:0] best_q, best_d;
  logic signed [aatp_pkg::ScoreW-1:0] best_score_q, best_score_d;

  logic          out_valid_q, out_valid_d;
  logic          found_q, found_d;
  logic [SW-1:0] oslot_q, oslot_d;
  logic signed [aatp_pkg::ScoreW-1:0] oscore_q, oscore_d;

  logic                    ram_we;
  aatp_pkg::slot_rec_t     ram_wdata, ram_rdata;
  logic [aatp_pkg::RecW-1:0] ram_rbits;

  logic          take;
  logic [SW-1:0] take_slot;
  logic [aatp_pkg::CntW-1:0] count_mid;
  logic          in_acc;
  logic [TW-1:0] div_eff;
  logic [TW:0]   sh, sh_sub;
  logic signed [aatp_pkg::ScoreW-1:0] score;
  logic          better;

  aatp_ram #(.Width(aatp_pkg::RecW), .Depth(N)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(task_slot_i),
    .wdata_i(ram_wdata),
    .raddr_i(idx_q),
    .rdata_o(ram_rbits)
  );
  assign ram_rdata = aatp_pkg::slot_rec_t'(ram_rbits);

  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  // divisor only changes while no scan is running
  assign cfg_ready_o = (state_q == StIdle);
  assign div_eff     = (div_q == '0) ? TW'(1) : div_q;

  assign ram_we    = in_acc && (cmd_i == aatp_pkg::CmdReady);
  assign ram_wdata = '{prio: task_priority_i, aff: affinity_i, stamp: now_tick_i};

  assign sh     = {rem_q, quo_q[TW-1]};
  assign sh_sub = sh - {1'b0, div_eff};
  assign score  = $signed({{(aatp_pkg::ScoreW-aatp_pkg::PrioW){1'b0}}, prio_q})
                - $signed({1'b0, quo_q});
  assign better = !have_q || (score < best_score_q) ||
                  ((score == best_score_q) && (rank_q[idx_q] < rank_q[best_q]));

  // ready set update: optional take-out, then optional append
  always_comb begin
    take      = 1'b0;
    take_slot = task_slot_i;
    if (in_acc && (cmd_i == aatp_pkg::CmdReady || cmd_i == aatp_pkg::CmdRemove)) begin
      take = 1'b1;
    end
    if (state_q == StDone && (!out_valid_q || out_ready_i) && have_q) begin
      take      = 1'b1;
      take_slot = best_q;
    end
    ready_d   = ready_q;
    rank_d    = rank_q;
    count_mid = count_q;
    if (take && ready_q[take_slot]) begin
      for (int i = 0; i < N; i++) begin
        if (ready_q[i] && rank_q[i] > rank_q[take_slot]) begin
          rank_d[i] = rank_q[i] - SW'(1);
        end
      end
      ready_d[take_slot] = 1'b0;
      count_mid = count_q - aatp_pkg::CntW'(1);
    end
    count_d = count_mid;
    if (ram_we) begin
      ready_d[task_slot_i] = 1'b1;
      rank_d[task_slot_i]  = count_mid[SW-1:0];
      count_d = count_mid + aatp_pkg::CntW'(1);
    end
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    core_d       = core_q;
    now_d        = now_q;
    prio_d       = prio_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    bit_d        = bit_q;
    have_d       = have_q;
    best_d       = best_q;
    best_score_d = best_score_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    found_d      = found_q;
    oslot_d      = oslot_q;
    oscore_d     = oscore_q;
    case (state_q)
      StIdle: begin
        if (in_acc && cmd_i == aatp_pkg::CmdSelect) begin
          idx_d   = '0;
          core_d  = core_i;
          now_d   = now_tick_i;
          have_d  = 1'b0;
          best_d  = '0;
          state_d = StRead;
        end
      end
      StRead: state_d = StLoad;
      StLoad: begin
        if (ready_q[idx_q] && ram_rdata.aff[core_q]) begin
          prio_d  = ram_rdata.prio;
          rem_d   = '0;
          quo_d   = now_q - ram_rdata.stamp;
          bit_d   = '0;
          state_d = StDiv;
        end else if (idx_q == SW'(N - 1)) begin
          state_d = StDone;
        end else begin
          idx_d   = idx_q + SW'(1);
          state_d = StRead;
        end
      end
      StDiv: begin
        // restoring division, one quotient bit per cycle
        if (!sh_sub[TW]) begin
          rem_d = sh_sub[TW-1:0];
          quo_d = {quo_q[TW-2:0], 1'b1};
        end else begin
          rem_d = sh[TW-1:0];
          quo_d = {quo_q[TW-2:0], 1'b0};
        end
        bit_d = bit_q + QW'(1);
        if (bit_q == QW'(TW - 1)) begin
          state_d = StCmp;
        end
      end
      StCmp: begin
        if (better) begin
          have_d       = 1'b1;
          best_d       = idx_q;
          best_score_d = score;
        end
        if (idx_q == SW'(N - 1)) begin
          state_d = StDone;
        end else begin
          idx_d   = idx_q + SW'(1);
          state_d = StRead;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          found_d     = have_q;
          oslot_d     = have_q ? best_q : '0;
          oscore_d    = have_q ? best_score_q : '0;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      div_q       <= TW'(1);
      ready_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ready_q     <= ready_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        div_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q       <= rank_d;
    idx_q        <= idx_d;
    core_q       <= core_d;
    now_q        <= now_d;
    prio_q       <= prio_d;
    rem_q        <= rem_d;
    quo_q        <= quo_d;
    bit_q        <= bit_d;
    have_q       <= have_d;
    best_q       <= best_d;
    best_score_q <= best_score_d;
    found_q      <= found_d;
    oslot_q      <= oslot_d;
    oscore_q     <= oscore_d;
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign chosen_slot_o  = oslot_q;
  assign chosen_score_o = oscore_q;
endmodule

/* design/aatp_checker.sv */
// Port-level checks for the task picker, bound to the top level.
`include "aging_affinity_task_picker_top_macros.svh"
module aatp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [aatp_pkg::CmdW-1:0]         cmd_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic                              found_o,
  input logic [aatp_pkg::SlotW-1:0]        chosen_slot_o,
  input logic signed [aatp_pkg::ScoreW-1:0] chosen_score_o
);
  `AATP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(found_o) && $stable(chosen_slot_o) && $stable(chosen_score_o), "result changed while stalled")
  `AATP_ASSERT_NOW(a_none_zero, out_valid_o && !found_o, chosen_slot_o == '0 && chosen_score_o == '0, "empty choice not zeroed")
  `AATP_ASSERT_NEXT(a_select_busy, in_valid_i && in_ready_o && cmd_i == aatp_pkg::CmdSelect, !in_ready_o, "select did not start a scan")
  `AATP_ASSERT_NOW(a_score_max, out_valid_o && found_o, chosen_score_o <= 33'sd255, "score above top priority")
endmodule

bind aging_affinity_task_picker_top aatp_checker u_aatp_checker (.*);
